// ----- src/kprt_pkg.sv -----
// kprt_pkg: shared types and constants of the key press/release tracker
// no dependencies; imported by kprt_list_store and key_press_release_tracker

package kprt_pkg;

    localparam int NUM_KEYS_DEF = 256;
    localparam int KEY_W        = 8;
    localparam int CNT_OUT_W    = 9;

    typedef enum logic [1:0] {
        CMD_KEY_EVENT = 2'd0,
        CMD_FRAME     = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        LIST_ACTIVE   = 2'd0,
        LIST_PRESSED  = 2'd1,
        LIST_RELEASED = 2'd2
    } t_list;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_DROP   = 2'd1,
        OP_APPEND = 2'd2,
        OP_READ   = 2'd3
    } t_eng_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACT_CHECK,
        ST_REL_DROP,
        ST_APPEND_ACT,
        ST_APPEND_PRS,
        ST_PRS_DROP,
        ST_APPEND_REL,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key_code;
        logic             key_down;
        logic [1:0]       list_select;
        logic [7:0]       entry_index;
    } t_in_item;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] num_active;
        logic [CNT_OUT_W-1:0] num_just_pressed;
        logic [CNT_OUT_W-1:0] num_just_released;
        logic [KEY_W-1:0]     read_key;
        logic                 read_valid;
        logic                 bad_key;
    } t_out_item;

    typedef struct packed {
        logic             start;
        t_eng_op          op;
        t_list            bank;
        logic [KEY_W-1:0] key;
    } t_eng_req;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [KEY_W-1:0] rd_key;
    } t_eng_sts;

endpackage

// ----- src/kprt_list_store.sv -----
// kprt_list_store: list memory for the three key lists with a streaming
// search/compact engine, append and indexed read; depends on kprt_pkg

module kprt_list_store import kprt_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_eng_req                         i_req,
    input  logic [$clog2(NUM_KEYS+1)-1:0]    i_count,
    output t_eng_sts                         o_sts
);

    localparam int AW    = $clog2(NUM_KEYS);
    localparam int CW    = $clog2(NUM_KEYS + 1);
    localparam int MAW   = AW + 2;
    localparam int DEPTH = 3 * (1 << AW);

    logic [KEY_W-1:0] mem [0:DEPTH-1];

    logic             r_busy, n_busy;
    t_eng_op          r_op, n_op;
    t_list            r_bank, n_bank;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]    r_len, n_len;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pos, n_pos;
    logic             r_found, n_found;
    logic [KEY_W-1:0] r_q;

    logic             rd_en, wr_en;
    logic [MAW-1:0]   rd_addr, wr_addr;
    logic [KEY_W-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
        end
        r_op    <= n_op;
        r_bank  <= n_bank;
        r_key   <= n_key;
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_found <= n_found;
    end

    always_comb begin
        n_busy  = r_busy;
        n_op    = r_op;
        n_bank  = r_bank;
        n_key   = r_key;
        n_len   = r_len;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_pos   = r_pos;
        n_found = r_found;
        rd_en   = 1'b0;
        rd_addr = {r_bank, r_idx[AW-1:0]};
        wr_en   = 1'b0;
        wr_addr = {r_bank, r_pos - AW'(1)};
        wr_data = r_q;
        o_sts.done   = 1'b0;
        o_sts.found  = r_found;
        o_sts.rd_key = r_q;

        if (i_req.start) begin
            n_op    = i_req.op;
            n_bank  = i_req.bank;
            n_key   = i_req.key;
            n_len   = i_count;
            n_idx   = '0;
            n_found = 1'b0;
            n_pend  = 1'b0;
            case (i_req.op)
                OP_READ: begin
                    rd_en   = 1'b1;
                    rd_addr = {i_req.bank, i_count[AW-1:0]};
                    n_busy  = 1'b1;
                    n_pend  = 1'b1;
                end
                OP_APPEND: begin
                    wr_en   = 1'b1;
                    wr_addr = {i_req.bank, i_count[AW-1:0]};
                    wr_data = i_req.key;
                    n_busy  = 1'b0;
                end
                default: begin
                    n_busy = 1'b1;
                end
            endcase
        end else if (r_busy) begin
            if (r_op == OP_READ) begin
                o_sts.done = 1'b1;
                n_busy     = 1'b0;
                n_pend     = 1'b0;
            end else begin
                // in a drop, entries behind the match move down by one place
                if (r_pend) begin
                    if (r_found) begin
                        wr_en = (r_op == OP_DROP);
                    end else if (r_q == r_key) begin
                        n_found = 1'b1;
                    end
                end
                if (r_idx != r_len) begin
                    rd_en  = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                    n_pos  = r_idx[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_sts.done = 1'b1;
                        n_busy     = 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ----- src/key_press_release_tracker.sv -----
// key_press_release_tracker: top level, command sequencer, list counts and
// result register; depends on kprt_pkg and kprt_list_store
//
// Keeps the set of held keys and two per-frame lists (just pressed, just
// released) in one list memory, all three ordered by arrival. A key event
// walks the lists through the memory's single read port, one entry per
// cycle: a press walks the active and just-released lists, a release the
// active and just-pressed lists. One transaction is in work at a time; the
// next one is taken while a finished result still waits on the output.
// Codes 0 and NUM_KEYS-1 and above are reported with bad_key and change
// nothing.

module key_press_release_tracker import kprt_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CW        = $clog2(NUM_KEYS + 1);
    localparam int LAST_CODE = NUM_KEYS - 1;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt_act, n_cnt_act;
    logic [CW-1:0]    r_cnt_prs, n_cnt_prs;
    logic [CW-1:0]    r_cnt_rel, n_cnt_rel;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_down, n_down;
    logic             r_bad, n_bad;
    logic [KEY_W-1:0] r_rd_key, n_rd_key;
    logic             r_rd_valid, n_rd_valid;
    t_eng_req         r_req, n_req;
    logic [CW-1:0]    r_req_count, n_req_count;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_eng_sts         eng_sts;
    logic [CW-1:0]    sel_cnt;
    logic             key_bad;
    logic             rd_ok;

    kprt_list_store #(
        .NUM_KEYS (NUM_KEYS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_count (r_req_count),
        .o_sts   (eng_sts)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign key_bad = (i_in_data.key_code == '0) || (int'(i_in_data.key_code) >= LAST_CODE);

    always_comb begin
        case (i_in_data.list_select)
            LIST_ACTIVE:   sel_cnt = r_cnt_act;
            LIST_PRESSED:  sel_cnt = r_cnt_prs;
            LIST_RELEASED: sel_cnt = r_cnt_rel;
            default:       sel_cnt = '0;
        endcase
    end

    assign rd_ok = int'(i_in_data.entry_index) < int'(sel_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_act   <= '0;
            r_cnt_prs   <= '0;
            r_cnt_rel   <= '0;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_act   <= n_cnt_act;
            r_cnt_prs   <= n_cnt_prs;
            r_cnt_rel   <= n_cnt_rel;
            r_req.start <= n_req.start;
            r_out_valid <= n_out_valid;
        end
        r_req.op    <= n_req.op;
        r_req.bank  <= n_req.bank;
        r_req.key   <= n_req.key;
        r_req_count <= n_req_count;
        r_key       <= n_key;
        r_down      <= n_down;
        r_bad       <= n_bad;
        r_rd_key    <= n_rd_key;
        r_rd_valid  <= n_rd_valid;
        r_out       <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt_act   = r_cnt_act;
        n_cnt_prs   = r_cnt_prs;
        n_cnt_rel   = r_cnt_rel;
        n_key       = r_key;
        n_down      = r_down;
        n_bad       = r_bad;
        n_rd_key    = r_rd_key;
        n_rd_valid  = r_rd_valid;
        n_req.start = 1'b0;
        n_req.op    = OP_SCAN;
        n_req.bank  = LIST_ACTIVE;
        n_req.key   = r_key;
        n_req_count = r_req_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key      = i_in_data.key_code;
                    n_down     = i_in_data.key_down;
                    n_bad      = 1'b0;
                    n_rd_key   = '0;
                    n_rd_valid = 1'b0;
                    n_state    = ST_RESP;
                    case (i_in_data.cmd)
                        CMD_KEY_EVENT: begin
                            if (key_bad) begin
                                n_bad = 1'b1;
                            end else begin
                                n_req.start = 1'b1;
                                n_req.op    = i_in_data.key_down ? OP_SCAN : OP_DROP;
                                n_req.bank  = LIST_ACTIVE;
                                n_req.key   = i_in_data.key_code;
                                n_req_count = r_cnt_act;
                                n_state     = ST_ACT_CHECK;
                            end
                        end
                        CMD_FRAME: begin
                            n_cnt_prs = '0;
                            n_cnt_rel = '0;
                        end
                        CMD_CLEAR: begin
                            n_cnt_act = '0;
                            n_cnt_prs = '0;
                            n_cnt_rel = '0;
                        end
                        default: begin
                            if (rd_ok) begin
                                n_req.start = 1'b1;
                                n_req.op    = OP_READ;
                                n_req.bank  = t_list'(i_in_data.list_select);
                                n_req_count = CW'(i_in_data.entry_index);
                                n_state     = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_ACT_CHECK: begin
                if (eng_sts.done) begin
                    if (r_down) begin
                        if (eng_sts.found) begin
                            n_state = ST_RESP;
                        end else begin
                            n_req.start = 1'b1;
                            n_req.op    = OP_DROP;
                            n_req.bank  = LIST_RELEASED;
                            n_req_count = r_cnt_rel;
                            n_state     = ST_REL_DROP;
                        end
                    end else begin
                        if (!eng_sts.found) begin
                            n_state = ST_RESP;
                        end else begin
                            n_cnt_act   = r_cnt_act - CW'(1);
                            n_req.start = 1'b1;
                            n_req.op    = OP_DROP;
                            n_req.bank  = LIST_PRESSED;
                            n_req_count = r_cnt_prs;
                            n_state     = ST_PRS_DROP;
                        end
                    end
                end
            end
            ST_REL_DROP: begin
                if (eng_sts.done) begin
                    if (eng_sts.found) begin
                        n_cnt_rel = r_cnt_rel - CW'(1);
                    end
                    n_state = ST_APPEND_ACT;
                end
            end
            ST_APPEND_ACT: begin
                if (int'(r_cnt_act) < NUM_KEYS) begin
                    n_req.start = 1'b1;
                    n_req.op    = OP_APPEND;
                    n_req.bank  = LIST_ACTIVE;
                    n_req_count = r_cnt_act;
                    n_cnt_act   = r_cnt_act + CW'(1);
                end
                n_state = ST_APPEND_PRS;
            end
            ST_APPEND_PRS: begin
                if (int'(r_cnt_prs) < NUM_KEYS) begin
                    n_req.start = 1'b1;
                    n_req.op    = OP_APPEND;
                    n_req.bank  = LIST_PRESSED;
                    n_req_count = r_cnt_prs;
                    n_cnt_prs   = r_cnt_prs + CW'(1);
                end
                n_state = ST_RESP;
            end
            ST_PRS_DROP: begin
                if (eng_sts.done) begin
                    if (eng_sts.found) begin
                        n_cnt_prs = r_cnt_prs - CW'(1);
                    end
                    n_state = ST_APPEND_REL;
                end
            end
            ST_APPEND_REL: begin
                if (int'(r_cnt_rel) < NUM_KEYS) begin
                    n_req.start = 1'b1;
                    n_req.op    = OP_APPEND;
                    n_req.bank  = LIST_RELEASED;
                    n_req_count = r_cnt_rel;
                    n_cnt_rel   = r_cnt_rel + CW'(1);
                end
                n_state = ST_RESP;
            end
            ST_READ: begin
                if (eng_sts.done) begin
                    n_rd_key   = eng_sts.rd_key;
                    n_rd_valid = 1'b1;
                    n_state    = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.num_active        = CNT_OUT_W'(r_cnt_act);
                    n_out.num_just_pressed  = CNT_OUT_W'(r_cnt_prs);
                    n_out.num_just_released = CNT_OUT_W'(r_cnt_rel);
                    n_out.read_key          = r_rd_key;
                    n_out.read_valid        = r_rd_valid;
                    n_out.bad_key           = r_bad;
                    n_out_valid             = 1'b1;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_idle_no_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_req.start)
        else $error("list engine request while idle");

    a_held_not_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cnt_act) + int'(r_cnt_rel)) <= (NUM_KEYS - 2))
        else $error("a key is both held and just released");

    a_release_shrinks_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACT_CHECK && eng_sts.done && !r_down && eng_sts.found)
        |=> (r_cnt_act == $past(r_cnt_act) - CW'(1)))
        else $error("release of a held key did not shrink the active list");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_sts.done |-> (r_state == ST_ACT_CHECK || r_state == ST_REL_DROP ||
                          r_state == ST_PRS_DROP || r_state == ST_READ))
        else $error("list engine finished with no sequencer waiting");

endmodule
